@@ rtl/escaped_frame_encoder_checksum_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame encoder
// Immediate-consequence and next-cycle implication forms, clocked and gated
// by reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_ENCODER_CHECKSUM_ASSERT_SVH
`define ESCAPED_FRAME_ENCODER_CHECKSUM_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define EFEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define EFEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/efec_pkg.sv @@
// ----------------------------------------------------------------------------
// efec_pkg
// Shared constants, types and helpers of the escaped frame encoder.
// ----------------------------------------------------------------------------
package efec_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // one classified input transaction, as queued between front and back
    typedef struct packed {
        logic [7:0] payload;
        logic       open;    // opening flag goes out first
        logic       last;    // checksum and closing flag follow
        logic [7:0] check;   // negated running sum, valid when last
    } efec_entry_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } efec_q_stat_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_OPEN,
        PH_DATA,
        PH_DATA_ESC,
        PH_CHK,
        PH_CHK_ESC,
        PH_CLOSE
    } efec_phase_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

@@ rtl/escaped_frame_encoder_checksum.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_encoder_checksum
// Byte-stuffing frame encoder with an 8-bit negated-sum checksum.
// ----------------------------------------------------------------------------
// Each input transaction yields 1 to 6 line bytes: an opening 0x7E at frame
// start, the payload byte (0x7D-escaped when it is 0x7E or 0x7D), and on the
// last byte the escaped checksum and a closing 0x7E flagged by frame_done.
// The back end sends one line byte per cycle while the receiver takes them,
// and an item stays at the queue head until its last line byte is loaded into
// the output register; the front takes one item per cycle while the
// QUEUE_DEPTH-entry queue between them has room. An accepted item is first
// written into the queue, and its line bytes then pass through the output register.
module escaped_frame_encoder_checksum #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       frame_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       run_last,
    output logic       frame_done
);
    import efec_pkg::*;

    efec_entry_t  push_data, head;
    efec_q_stat_t q_stat;
    logic         push, pop;

    efec_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    efec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    efec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_byte  (line_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

endmodule

@@ rtl/efec_fifo.sv @@
// ----------------------------------------------------------------------------
// efec_fifo
// Small show-ahead queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module efec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  efec_pkg::efec_entry_t push_data,
    input  logic                  pop,
    output efec_pkg::efec_entry_t head,
    output efec_pkg::efec_q_stat_t stat
);
    import efec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    efec_entry_t        entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head           = entries_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != CNT_W'(DEPTH));

endmodule

@@ rtl/efec_front.sv @@
// ----------------------------------------------------------------------------
// efec_front
// Accepts payload bytes, tracks frame state and the running sum, and queues
// one classified entry per transaction.
// ----------------------------------------------------------------------------
module efec_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             payload_byte,
    input  logic                   frame_last,
    input  efec_pkg::efec_q_stat_t q_stat,
    output logic                   push,
    output efec_pkg::efec_entry_t  push_data
);
    import efec_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] sum_plus;

    assign in_ready = q_stat.not_full;
    assign push     = in_valid && in_ready;
    assign sum_plus = sum_reg + payload_byte;

    always_comb
    begin
        push_data.payload = payload_byte;
        push_data.open    = !in_frame_reg;
        push_data.last    = frame_last;
        push_data.check   = 8'h00 - sum_plus;

        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        if (push)
        begin
            in_frame_next = !frame_last;
            sum_next      = frame_last ? 8'h00 : sum_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'h00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

@@ rtl/efec_back.sv @@
// ----------------------------------------------------------------------------
// efec_back
// Walks the queue head through flag, stuffed payload, stuffed checksum and
// closing flag, one byte per cycle into an output register unless stalled.
// ----------------------------------------------------------------------------
module efec_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  efec_pkg::efec_entry_t  head,
    input  efec_pkg::efec_q_stat_t q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             line_byte,
    output logic                   run_last,
    output logic                   frame_done
);
    import efec_pkg::*;

    efec_phase_t phase_reg, phase_next, eff;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  line_byte_reg, line_byte_next;
    logic        run_last_reg, run_last_next;
    logic        frame_done_reg, frame_done_next;
    logic        step;
    logic [7:0]  emit_byte;
    logic        emit_last, emit_done;
    efec_phase_t after;

    // queue not empty, and output register free or being drained this cycle
    assign step = q_stat.not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        eff = phase_reg;
        if (phase_reg == PH_HEAD)
        begin
            eff = head.open ? PH_OPEN : PH_DATA;
        end

        emit_byte = FLAG_BYTE;
        emit_last = 1'b0;
        emit_done = 1'b0;
        after     = PH_HEAD;
        case (eff)
            PH_OPEN:
            begin
                emit_byte = FLAG_BYTE;
                after     = PH_DATA;
            end
            PH_DATA:
            begin
                if (needs_escape(head.payload))
                begin
                    emit_byte = ESC_BYTE;
                    after     = PH_DATA_ESC;
                end
                else
                begin
                    emit_byte = head.payload;
                    after     = head.last ? PH_CHK : PH_HEAD;
                    emit_last = !head.last;
                end
            end
            PH_DATA_ESC:
            begin
                emit_byte = head.payload ^ ESC_XOR;
                after     = head.last ? PH_CHK : PH_HEAD;
                emit_last = !head.last;
            end
            PH_CHK:
            begin
                if (needs_escape(head.check))
                begin
                    emit_byte = ESC_BYTE;
                    after     = PH_CHK_ESC;
                end
                else
                begin
                    emit_byte = head.check;
                    after     = PH_CLOSE;
                end
            end
            PH_CHK_ESC:
            begin
                emit_byte = head.check ^ ESC_XOR;
                after     = PH_CLOSE;
            end
            PH_CLOSE:
            begin
                emit_byte = FLAG_BYTE;
                emit_last = 1'b1;
                emit_done = 1'b1;
                after     = PH_HEAD;
            end
            default:
            begin
                emit_byte = FLAG_BYTE;
                after     = PH_HEAD;
            end
        endcase

        pop             = step && emit_last;
        phase_next      = step ? after : phase_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        line_byte_next  = line_byte_reg;
        run_last_next   = run_last_reg;
        frame_done_next = frame_done_reg;
        if (step)
        begin
            out_valid_next  = 1'b1;
            line_byte_next  = emit_byte;
            run_last_next   = emit_last;
            frame_done_next = emit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_byte_reg  <= line_byte_next;
        run_last_reg   <= run_last_next;
        frame_done_reg <= frame_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign line_byte  = line_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

endmodule

@@ rtl/efec_checker.sv @@
// ----------------------------------------------------------------------------
// efec_checker
// Port-level checks of the encoder's line output, bound to the top level.
// ----------------------------------------------------------------------------
`include "escaped_frame_encoder_checksum_assert.svh"

module efec_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line_byte,
    input logic       run_last,
    input logic       frame_done
);
    import efec_pkg::*;

    `EFEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(line_byte) && $stable(run_last) && $stable(frame_done), "line output changed while stalled")
    `EFEC_ASSERT_NOW(a_close_flag, clk, rst_n, out_valid && frame_done, (line_byte == FLAG_BYTE) && run_last, "closing transaction is not a final flag")
    `EFEC_ASSERT_NOW(a_open_flag, clk, rst_n, out_valid && (line_byte == FLAG_BYTE) && !frame_done, !run_last, "opening flag ends a run")
    `EFEC_ASSERT_NOW(a_esc_pair, clk, rst_n, out_valid && (line_byte == ESC_BYTE), !run_last && !frame_done, "escape byte without its partner")

endmodule

bind escaped_frame_encoder_checksum efec_checker u_efec_checker (.*);

@@ test/escaped_frame_encoder_checksum_tb.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_encoder_checksum_tb
// Drives payload bytes in frames of random length through the encoder and
// checks every line byte, together with its run_last and frame_done marks,
// against an in-bench byte-stuffing and checksum predictor. The sender
// works in bursts with gaps between them, and the receiver stalls.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_checksum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import efec_pkg::*;

    localparam int RANDOM_ITEMS  = 460;
    localparam int LONG_STALL    = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] payload;
        logic       last;
    } payload_item_t;

    typedef struct packed {
        logic [7:0] line;
        logic       run_last;
        logic       frame_done;
    } line_result_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_MOSTLY,
        RX_EVERY_THIRD,
        RX_COIN
    } rx_mode_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] payload_byte = 8'h00;
    logic       frame_last   = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;

    payload_item_t pending_q[$];
    line_result_t  line_expect_q[$];
    line_result_t  line_run_q[$];

    // predictor state
    logic       frame_open = 1'b0;
    logic [7:0] frame_sum  = 8'h00;

    payload_item_t cur_item;
    int            burst_left;
    int            gap_left;
    rx_mode_t      rx_mode;
    int            rx_mode_left;
    int            rx_tick;
    int            stall_left;
    bit            long_stall_req = 1'b0;
    int            idle_cycles;
    int            mismatch_count = 0;
    line_result_t  got_line;
    line_result_t  want_line;

    escaped_frame_encoder_checksum u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_byte    (line_byte),
        .run_last     (run_last),
        .frame_done   (frame_done)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic add_line(input logic [7:0] b, input logic done);
        line_result_t r;
        r.line       = b;
        r.run_last   = 1'b0;
        r.frame_done = done;
        line_run_q.push_back(r);
    endtask

    task automatic stuff_line(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE)
        begin
            add_line(ESC_BYTE, 1'b0);
            add_line(b ^ ESC_XOR, 1'b0);
        end
        else
        begin
            add_line(b, 1'b0);
        end
    endtask

    // expected line bytes for one accepted transaction
    task automatic encode_transaction(input payload_item_t it);
        logic [7:0] chk;
        line_run_q.delete();
        if (!frame_open)
        begin
            add_line(FLAG_BYTE, 1'b0);
            frame_open = 1'b1;
        end
        stuff_line(it.payload);
        frame_sum = frame_sum + it.payload;
        if (it.last)
        begin
            chk = 8'h00 - frame_sum;
            stuff_line(chk);
            add_line(FLAG_BYTE, 1'b1);
            frame_open = 1'b0;
            frame_sum  = 8'h00;
        end
        line_run_q[line_run_q.size() - 1].run_last = 1'b1;
        foreach (line_run_q[i])
            line_expect_q.push_back(line_run_q[i]);
    endtask

    task automatic queue_item(input logic [7:0] b, input logic last);
        payload_item_t it;
        it.payload = b;
        it.last    = last;
        pending_q.push_back(it);
    endtask

    task automatic wait_for_drain();
        while (pending_q.size() != 0 || in_valid || line_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            payload_byte <= 8'h00;
            frame_last   <= 1'b0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_transaction(cur_item);
            if (!(in_valid && !in_ready))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    cur_item = pending_q.pop_front();
                    burst_left--;
                    in_valid     <= 1'b1;
                    payload_byte <= cur_item.payload;
                    frame_last   <= cur_item.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_mode      = RX_FREE;
            rx_mode_left = 0;
            rx_tick      = 0;
            stall_left   = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_FREE:        out_ready <= 1'b1;
                RX_MOSTLY:      out_ready <= ($urandom_range(0, 3) != 0);
                RX_EVERY_THIRD: out_ready <= (rx_tick % 3 != 0);
                default:        out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_line.line       = line_byte;
            got_line.run_last   = run_last;
            got_line.frame_done = frame_done;
            if (line_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected line byte %02h", got_line.line));
            end
            else
            begin
                want_line = line_expect_q.pop_front();
                if (got_line.line !== want_line.line)
                    report_mismatch($sformatf("line_byte %02h, expected %02h",
                                              got_line.line, want_line.line));
                if (got_line.run_last !== want_line.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                              got_line.run_last, want_line.run_last,
                                              want_line.line));
                if (got_line.frame_done !== want_line.frame_done)
                    report_mismatch($sformatf("frame_done %b, expected %b on byte %02h",
                                              got_line.frame_done, want_line.frame_done,
                                              want_line.line));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL escaped_frame_encoder_checksum");
            $finish;
        end
    end

    initial
    begin
        int            n;
        int            len;
        int            k;
        logic [7:0]    b;
        logic [7:0]    sum;
        bit            did_stall;
        bit            did_pause;

        n         = 0;
        did_stall = 1'b0;
        did_pause = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-byte frames: plain, all ones, escaped payload, escaped checksum
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b1);
        queue_item(FLAG_BYTE, 1'b1);
        queue_item(ESC_BYTE, 1'b1);
        queue_item(8'h00 - FLAG_BYTE, 1'b1);
        queue_item(8'h00 - ESC_BYTE, 1'b1);
        queue_item(8'h80, 1'b1);
        // both escapes mid-frame; last byte brings the sum to 0x82, checksum 0x7E
        queue_item(8'h01, 1'b0);
        queue_item(ESC_BYTE, 1'b0);
        queue_item(FLAG_BYTE, 1'b0);
        queue_item(8'h86, 1'b1);
        // sum wraps
        queue_item(8'hFF, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'hFF, 1'b1);
        // checksum 0x7D
        queue_item(8'h40, 1'b0);
        queue_item(8'h43, 1'b1);
        // already-xored look-alikes go out unchanged
        queue_item(FLAG_BYTE ^ ESC_XOR, 1'b0);
        queue_item(ESC_BYTE ^ ESC_XOR, 1'b0);
        queue_item(ESC_XOR, 1'b1);
        wait_for_drain();

        while (n < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            sum = 8'h00;
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       b = FLAG_BYTE;
                    1:       b = ESC_BYTE;
                    2:       b = FLAG_BYTE ^ ESC_XOR;
                    3:       b = ESC_BYTE ^ ESC_XOR;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                // now and then steer the checksum onto a byte that needs escaping
                if (k == len - 1 && $urandom_range(0, 5) == 0)
                    b = 8'h00 - ($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE) - sum;
                sum = sum + b;
                queue_item(b, k == len - 1);
                n++;
            end
            if (!did_stall && n >= 180)
            begin
                while (pending_q.size() > 8)
                    @(posedge clk);
                @(negedge clk);
                long_stall_req = 1'b1;
                did_stall      = 1'b1;
            end
            if (!did_pause && n >= 320)
            begin
                wait_for_drain();
                did_pause = 1'b1;
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && line_expect_q.size() == 0)
            $display("PASS escaped_frame_encoder_checksum");
        else
            $display("FAIL escaped_frame_encoder_checksum");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/efec_pkg.sv
rtl/efec_fifo.sv
rtl/efec_front.sv
rtl/efec_back.sv
rtl/escaped_frame_encoder_checksum.sv
rtl/efec_checker.sv
test/escaped_frame_encoder_checksum_tb.sv
